// File: sv/lcdnw_pkg.sv
// Shared types and constants for the character LCD number writer.
// Holds the microcode word layout and the sequencer program ROM.
// No dependencies.
package lcdnw_pkg;

  // Request kinds
  localparam logic [1:0] KIND_INIT     = 2'd0;
  localparam logic [1:0] KIND_CHAR     = 2'd1;
  localparam logic [1:0] KIND_UNSIGNED = 2'd2;
  localparam logic [1:0] KIND_SIGNED   = 2'd3;

  // LCD command bytes
  localparam logic [7:0] CMD_FUNC_SET   = 8'h38;
  localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
  localparam logic [7:0] CMD_DISP_ON    = 8'h0C;
  localparam logic [7:0] CMD_CLEAR      = 8'h01;
  localparam logic [7:0] CMD_LINE1      = 8'h80;
  localparam logic [7:0] CMD_LINE2      = 8'hC0;

  // ASCII characters
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_PLUS  = 8'h2B;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;

  // Binary to BCD conversion
  localparam int unsigned VALUE_BITS = 16;
  localparam int unsigned BCD_DIGITS = 5;
  localparam int unsigned CONV_CNT_W = $clog2(VALUE_BITS + 1);

  // Sequencer program
  localparam int unsigned PC_W = 4;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_CURSOR,
    OP_SIGN,
    OP_DABBLE,
    OP_DIGIT,
    OP_CHAR,
    OP_CONST,
    OP_DONE
  } op_t;

  typedef enum logic [2:0] {
    JC_NEVER,
    JC_KIND_INIT,
    JC_KIND_CHAR,
    JC_KIND_UNSIGNED,
    JC_CONV_MORE,
    JC_DIGITS_ZERO,
    JC_DIGITS_MORE
  } jcond_t;

  typedef struct packed {
    op_t              op;
    jcond_t           jcond;
    logic [PC_W-1:0]  target;
    logic [7:0]       byte_arg;
  } uword_t;

  // Program ROM: one control word per step
  function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{op: OP_DONE, jcond: JC_NEVER, target: '0, byte_arg: '0};
    unique case (pc)
      4'd0:  w = '{op: OP_NOP,    jcond: JC_KIND_INIT,     target: 4'd10, byte_arg: 8'h00};
      4'd1:  w = '{op: OP_CURSOR, jcond: JC_KIND_CHAR,     target: 4'd8,  byte_arg: 8'h00};
      4'd2:  w = '{op: OP_NOP,    jcond: JC_KIND_UNSIGNED, target: 4'd4,  byte_arg: 8'h00};
      4'd3:  w = '{op: OP_SIGN,   jcond: JC_NEVER,         target: 4'd0,  byte_arg: 8'h00};
      4'd4:  w = '{op: OP_DABBLE, jcond: JC_CONV_MORE,     target: 4'd4,  byte_arg: 8'h00};
      4'd5:  w = '{op: OP_NOP,    jcond: JC_DIGITS_ZERO,   target: 4'd7,  byte_arg: 8'h00};
      4'd6:  w = '{op: OP_DIGIT,  jcond: JC_DIGITS_MORE,   target: 4'd6,  byte_arg: 8'h00};
      4'd7:  w = '{op: OP_DONE,   jcond: JC_NEVER,         target: 4'd0,  byte_arg: 8'h00};
      4'd8:  w = '{op: OP_CHAR,   jcond: JC_NEVER,         target: 4'd0,  byte_arg: 8'h00};
      4'd9:  w = '{op: OP_DONE,   jcond: JC_NEVER,         target: 4'd0,  byte_arg: 8'h00};
      4'd10: w = '{op: OP_CONST,  jcond: JC_NEVER,         target: 4'd0,
                   byte_arg: CMD_FUNC_SET};
      4'd11: w = '{op: OP_CONST,  jcond: JC_NEVER,         target: 4'd0,
                   byte_arg: CMD_ENTRY_MODE};
      4'd12: w = '{op: OP_CONST,  jcond: JC_NEVER,         target: 4'd0,
                   byte_arg: CMD_DISP_ON};
      4'd13: w = '{op: OP_CONST,  jcond: JC_NEVER,         target: 4'd0,
                   byte_arg: CMD_CLEAR};
      default: w = '{op: OP_DONE, jcond: JC_NEVER,         target: 4'd0,  byte_arg: 8'h00};
    endcase
    return w;
  endfunction

endpackage

// File: sv/char_lcd_number_writer_unit.sv
// Top level of the character LCD number writer: microcoded sequencer and datapath.
// Depends on lcdnw_pkg for the control word layout and program ROM.

// A request is taken when start is high and busy is low; busy then stays high
// until its last write has gone out. Each LCD write appears on is_data/bus_byte
// for one cycle with strobe high, and last marks the final write of a request.
// The receiver cannot stall, so every strobe must be captured. After its transfer
// cycle a request runs one program step per cycle and busy falls with its last
// step: init takes 6 steps, a single character 4, an unsigned number 21 to 26 and
// a signed number 22 to 27 (the 16-step binary to BCD loop plus one step per
// digit, with the default MAX_DIGITS). A new request can transfer in the cycle
// after busy falls. Writes are held in a pending register until the next write
// or the end of the request, so that last is known when they go out; a request
// with nothing to send ends without any strobe.
module char_lcd_number_writer_unit #(
  parameter int MAX_DIGITS = 5
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] kind,
  input  logic [1:0] line,
  input  logic [5:0] column,
  input  logic [7:0] char_code,
  input  logic [15:0] value,
  input  logic [2:0] digit_count,
  output logic       strobe,
  output logic       is_data,
  output logic [7:0] bus_byte,
  output logic       last
);

  localparam int unsigned VW = lcdnw_pkg::VALUE_BITS;
  localparam int unsigned ND = lcdnw_pkg::BCD_DIGITS;

  // Request registers
  logic [1:0]  req_kind;
  logic [1:0]  req_line;
  logic [5:0]  req_column;
  logic [7:0]  req_char;
  logic        req_positive;
  logic [2:0]  digits_left;

  // Sequencer and datapath registers
  logic [lcdnw_pkg::PC_W-1:0]       pc;
  logic [lcdnw_pkg::CONV_CNT_W-1:0] conv_cnt;
  logic [VW-1:0]                    mag;
  logic [3:0]                       bcd [ND];

  // Pending write, sent once the next write or the end is known
  logic        pend_valid;
  logic        pend_is_data;
  logic [7:0]  pend_byte;

  lcdnw_pkg::uword_t uw;
  logic        jump;
  logic        emit;
  logic        emit_is_data;
  logic [7:0]  emit_byte;
  logic [7:0]  col_off;
  logic [2:0]  digit_pos;
  logic [3:0]  digit_val;
  logic [3:0]  bcd_adj [ND];
  logic [15:0] value_neg;
  logic        value_positive;
  logic [2:0]  count_sat;

  assign uw = lcdnw_pkg::ucode_rom(pc);

  // Decode jump condition
  always_comb begin
    unique case (uw.jcond)
      lcdnw_pkg::JC_KIND_INIT:     jump = (req_kind == lcdnw_pkg::KIND_INIT);
      lcdnw_pkg::JC_KIND_CHAR:     jump = (req_kind == lcdnw_pkg::KIND_CHAR);
      lcdnw_pkg::JC_KIND_UNSIGNED: jump = (req_kind == lcdnw_pkg::KIND_UNSIGNED);
      lcdnw_pkg::JC_CONV_MORE:     jump = (conv_cnt != lcdnw_pkg::CONV_CNT_W'(1));
      lcdnw_pkg::JC_DIGITS_ZERO:   jump = (digits_left == 3'd0);
      lcdnw_pkg::JC_DIGITS_MORE:   jump = (digits_left != 3'd1);
      default:                     jump = 1'b0;
    endcase
  end

  // Select the digit for the current position; positions past the BCD word are zero
  always_comb begin
    digit_pos = digits_left - 3'd1;
    digit_val = 4'd0;
    if (32'(digit_pos) < ND) begin
      digit_val = bcd[digit_pos];
    end
  end

  // Add 3 to every BCD digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < ND; i++) begin
      bcd_adj[i] = (bcd[i] >= 4'd5) ? bcd[i] + 4'd3 : bcd[i];
    end
  end

  // Build the write for this step
  assign col_off = {2'b00, req_column} - 8'd1;
  always_comb begin
    emit         = 1'b0;
    emit_is_data = 1'b0;
    emit_byte    = 8'h00;
    case (uw.op)
      lcdnw_pkg::OP_CURSOR: begin
        emit      = (req_line == 2'd1) || (req_line == 2'd2);
        emit_byte = ((req_line == 2'd1) ? lcdnw_pkg::CMD_LINE1 : lcdnw_pkg::CMD_LINE2)
                    | col_off;
      end
      lcdnw_pkg::OP_SIGN: begin
        emit         = 1'b1;
        emit_is_data = 1'b1;
        emit_byte    = req_positive ? lcdnw_pkg::ASCII_PLUS : lcdnw_pkg::ASCII_MINUS;
      end
      lcdnw_pkg::OP_DIGIT: begin
        emit         = 1'b1;
        emit_is_data = 1'b1;
        emit_byte    = lcdnw_pkg::ASCII_ZERO | {4'h0, digit_val};
      end
      lcdnw_pkg::OP_CHAR: begin
        emit         = 1'b1;
        emit_is_data = 1'b1;
        emit_byte    = req_char;
      end
      lcdnw_pkg::OP_CONST: begin
        emit      = 1'b1;
        emit_byte = uw.byte_arg;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Sign and magnitude of the request value; saturate the digit count
  assign value_positive = (value != 16'd0) && !value[15];
  assign value_neg      = 16'd0 - value;
  assign count_sat      = (int'(digit_count) > MAX_DIGITS) ? 3'(MAX_DIGITS) : digit_count;

  // Sequencer, datapath and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      pc         <= '0;
      pend_valid <= 1'b0;
      strobe     <= 1'b0;
      last       <= 1'b0;
    end else begin
      strobe <= 1'b0;
      last   <= 1'b0;
      if (!busy) begin
        // Capture a new request
        if (start) begin
          busy         <= 1'b1;
          pc           <= '0;
          req_kind     <= kind;
          req_line     <= line;
          req_column   <= column;
          req_char     <= char_code;
          req_positive <= value_positive;
          digits_left  <= count_sat;
          conv_cnt     <= lcdnw_pkg::CONV_CNT_W'(VW);
          mag          <= (kind == lcdnw_pkg::KIND_SIGNED && !value_positive)
                          ? value_neg : value;
          for (int i = 0; i < ND; i++) begin
            bcd[i] <= 4'd0;
          end
        end
      end else begin
        // Advance the program counter
        pc <= jump ? uw.target : pc + lcdnw_pkg::PC_W'(1);

        // Shift one magnitude bit into the BCD digits
        if (uw.op == lcdnw_pkg::OP_DABBLE) begin
          bcd[0]   <= {bcd_adj[0][2:0], mag[VW-1]};
          for (int i = 1; i < ND; i++) begin
            bcd[i] <= {bcd_adj[i][2:0], bcd_adj[i-1][3]};
          end
          mag      <= {mag[VW-2:0], 1'b0};
          conv_cnt <= conv_cnt - lcdnw_pkg::CONV_CNT_W'(1);
        end

        if (uw.op == lcdnw_pkg::OP_DIGIT) begin
          digits_left <= digits_left - 3'd1;
        end

        // Push the new write, sending the pending one
        if (emit) begin
          strobe       <= pend_valid;
          is_data      <= pend_is_data;
          bus_byte     <= pend_byte;
          pend_valid   <= 1'b1;
          pend_is_data <= emit_is_data;
          pend_byte    <= emit_byte;
        end

        // Flush the final write and drop busy
        if (uw.op == lcdnw_pkg::OP_DONE) begin
          busy       <= 1'b0;
          strobe     <= pend_valid;
          last       <= pend_valid;
          is_data    <= pend_is_data;
          bus_byte   <= pend_byte;
          pend_valid <= 1'b0;
        end
      end
    end
  end

endmodule

// File: sv/lcdnw_checker.sv
// Port-level checker for the character LCD number writer, with its bind.
// Depends only on the ports of char_lcd_number_writer_unit.
module lcdnw_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic strobe,
  input logic last
);

  // An accepted request holds busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after transfer of a request");

  // Every write belongs to a request that was in progress
  a_strobe_in_request: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("write outside a request");

  // The final write coincides with busy dropping
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> !busy && $past(busy))
    else $error("last write does not end the request");

  // A write seen after busy has dropped must be the final one
  a_idle_write_last: assert property (@(posedge clk) disable iff (rst)
    strobe && !busy |-> last)
    else $error("non-final write after request end");

  // Nothing follows the final write in the next cycle
  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    strobe && last |=> !strobe)
    else $error("write directly after final write");

endmodule

bind char_lcd_number_writer_unit lcdnw_checker u_lcdnw_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .strobe (strobe),
  .last   (last)
);

// File: tb/sv/char_lcd_number_writer_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the character LCD number writer (char_lcd_number_writer_unit).
// Predicts every LCD bus write per request in a small scoreboard class; depends on lcdnw_pkg.
module char_lcd_number_writer_unit_test;

  localparam int DIGIT_LIMIT     = 5;
  localparam int RANDOM_REQUESTS = 236;
  localparam int DRAIN_CYCLES    = 40;
  localparam int CYCLE_LIMIT     = 200000;

  typedef struct packed {
    logic       is_data;
    logic [7:0] bus_byte;
    logic       last;
  } lcd_write_t;

  // Expected LCD writes, filled per accepted request and drained per strobe
  class lcd_write_scoreboard;
    lcd_write_t expected_writes[$];
    int errors = 0;

    task report(string msg);
      errors++;
      $display("ERROR: %s", msg);
    endtask

    function void push_write(logic d, logic [7:0] b);
      expected_writes.push_back('{is_data: d, bus_byte: b, last: 1'b0});
    endfunction

    function int pending();
      return expected_writes.size();
    endfunction

    // Build the run of writes that one request causes
    task note_request(logic [1:0] k, logic [1:0] line_sel, logic [5:0] col,
                      logic [7:0] ch, logic [15:0] val, logic [2:0] cnt);
      int unsigned first;
      int unsigned mag;
      int unsigned ndig;
      int unsigned scale;
      logic [7:0] offset;
      first = expected_writes.size();
      if (k == lcdnw_pkg::KIND_INIT) begin
        push_write(1'b0, lcdnw_pkg::CMD_FUNC_SET);
        push_write(1'b0, lcdnw_pkg::CMD_ENTRY_MODE);
        push_write(1'b0, lcdnw_pkg::CMD_DISP_ON);
        push_write(1'b0, lcdnw_pkg::CMD_CLEAR);
      end else begin
        // cursor command only for lines one and two; column zero wraps
        offset = {2'b00, col} - 8'd1;
        if (line_sel == 2'd1) push_write(1'b0, lcdnw_pkg::CMD_LINE1 | offset);
        else if (line_sel == 2'd2) push_write(1'b0, lcdnw_pkg::CMD_LINE2 | offset);
        if (k == lcdnw_pkg::KIND_CHAR) begin
          push_write(1'b1, ch);
        end else begin
          mag = val;
          if (k == lcdnw_pkg::KIND_SIGNED) begin
            if (val != 16'd0 && !val[15]) begin
              push_write(1'b1, lcdnw_pkg::ASCII_PLUS);
            end else begin
              // zero shows a minus sign; magnitude uses the full 16 bits
              push_write(1'b1, lcdnw_pkg::ASCII_MINUS);
              mag = (32'h10000 - val) & 32'h1FFFF;
              if (val == 16'd0) mag = 0;
            end
          end
          ndig = (cnt > DIGIT_LIMIT) ? DIGIT_LIMIT : cnt;
          for (int i = ndig; i > 0; i--) begin
            scale = 1;
            for (int j = 1; j < i; j++) scale *= 10;
            push_write(1'b1, lcdnw_pkg::ASCII_ZERO + 8'((mag / scale) % 10));
          end
        end
      end
      if (expected_writes.size() > first)
        expected_writes[expected_writes.size() - 1].last = 1'b1;
    endtask

    // Compare one observed write with the oldest expectation
    task check_write(logic d, logic [7:0] b, logic l);
      lcd_write_t want;
      if (expected_writes.size() == 0) begin
        report($sformatf("write with nothing expected: is_data=%0b bus_byte=%02h last=%0b",
                         d, b, l));
      end else begin
        want = expected_writes.pop_front();
        if (want.is_data !== d || want.bus_byte !== b || want.last !== l)
          report($sformatf("write: got is_data=%0b bus_byte=%02h last=%0b, want %0b %02h %0b",
                           d, b, l, want.is_data, want.bus_byte, want.last));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  kind = '0;
  logic [1:0]  line = '0;
  logic [5:0]  column = '0;
  logic [7:0]  char_code = '0;
  logic [15:0] value = '0;
  logic [2:0]  digit_count = '0;
  logic        strobe;
  logic        is_data;
  logic [7:0]  bus_byte;
  logic        last;
  int          cycle_count = 0;

  lcd_write_scoreboard writes_sb = new();

  char_lcd_number_writer_unit #(.MAX_DIGITS(DIGIT_LIMIT)) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .kind(kind), .line(line), .column(column), .char_code(char_code),
    .value(value), .digit_count(digit_count),
    .strobe(strobe), .is_data(is_data), .bus_byte(bus_byte), .last(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Check every strobed write; the receiver never stalls
  always @(posedge clk) begin
    if (!rst && strobe) writes_sb.check_write(is_data, bus_byte, last);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("char_lcd_number_writer_unit: mismatch");
      $finish;
    end
  end

  // Idle for gap cycles, then hold the request until it transfers
  task send_request(logic [1:0] k, logic [1:0] line_sel, logic [5:0] col,
                    logic [7:0] ch, logic [15:0] val, logic [2:0] cnt, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    kind        <= k;
    line        <= line_sel;
    column      <= col;
    char_code   <= ch;
    value       <= val;
    digit_count <= cnt;
    @(posedge clk);
    while (busy) @(posedge clk);
    writes_sb.note_request(k, line_sel, col, ch, val, cnt);
  endtask

  initial begin
    logic [1:0]  r_kind;
    logic [1:0]  r_line;
    logic [5:0]  r_col;
    logic [15:0] r_val;
    logic [2:0]  r_cnt;
    int          gap;
    int          pick;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, every kind, and the corner cases
    send_request(lcdnw_pkg::KIND_INIT,     2'd0, 6'd0,  8'h00, 16'h0000, 3'd0, 1);
    send_request(lcdnw_pkg::KIND_CHAR,     2'd1, 6'd1,  8'h00, 16'h0000, 3'd0, 0);
    send_request(lcdnw_pkg::KIND_CHAR,     2'd2, 6'd40, 8'hFF, 16'hFFFF, 3'd7, 0);
    send_request(lcdnw_pkg::KIND_CHAR,     2'd0, 6'd5,  8'h41, 16'h1234, 3'd2, 3);
    send_request(lcdnw_pkg::KIND_CHAR,     2'd3, 6'd63, 8'h7E, 16'h0000, 3'd5, 0);
    send_request(lcdnw_pkg::KIND_CHAR,     2'd1, 6'd0,  8'h5A, 16'h0000, 3'd0, 2);
    send_request(lcdnw_pkg::KIND_CHAR,     2'd2, 6'd63, 8'hA5, 16'h0000, 3'd0, 0);
    send_request(lcdnw_pkg::KIND_UNSIGNED, 2'd1, 6'd1,  8'h00, 16'hFFFF, 3'd5, 0);
    send_request(lcdnw_pkg::KIND_UNSIGNED, 2'd2, 6'd10, 8'h00, 16'h0000, 3'd5, 4);
    send_request(lcdnw_pkg::KIND_UNSIGNED, 2'd1, 6'd3,  8'h00, 16'd12345, 3'd3, 0);
    send_request(lcdnw_pkg::KIND_UNSIGNED, 2'd2, 6'd20, 8'h00, 16'd54321, 3'd7, 0);
    send_request(lcdnw_pkg::KIND_UNSIGNED, 2'd1, 6'd41, 8'h00, 16'd9, 3'd6, 1);
    send_request(lcdnw_pkg::KIND_UNSIGNED, 2'd0, 6'd7,  8'h00, 16'd777, 3'd0, 0);
    send_request(lcdnw_pkg::KIND_UNSIGNED, 2'd3, 6'd7,  8'hFF, 16'hFFFF, 3'd0, 0);
    send_request(lcdnw_pkg::KIND_UNSIGNED, 2'd1, 6'd16, 8'h00, 16'd42, 3'd0, 0);
    send_request(lcdnw_pkg::KIND_UNSIGNED, 2'd3, 6'd2,  8'h00, 16'd9, 3'd1, 5);
    send_request(lcdnw_pkg::KIND_SIGNED,   2'd1, 6'd1,  8'h00, 16'h0000, 3'd5, 0);
    send_request(lcdnw_pkg::KIND_SIGNED,   2'd2, 6'd2,  8'h00, 16'h0001, 3'd5, 0);
    send_request(lcdnw_pkg::KIND_SIGNED,   2'd1, 6'd40, 8'h00, 16'h7FFF, 3'd5, 9);
    send_request(lcdnw_pkg::KIND_SIGNED,   2'd2, 6'd8,  8'h00, 16'h8000, 3'd5, 0);
    send_request(lcdnw_pkg::KIND_SIGNED,   2'd1, 6'd9,  8'h00, 16'hFFFF, 3'd5, 0);
    send_request(lcdnw_pkg::KIND_SIGNED,   2'd0, 6'd9,  8'h00, 16'd300, 3'd0, 2);
    send_request(lcdnw_pkg::KIND_SIGNED,   2'd3, 6'd9,  8'h00, 16'h8000, 3'd7, 0);
    send_request(lcdnw_pkg::KIND_SIGNED,   2'd2, 6'd33, 8'h00, 16'd100, 3'd2, 0);
    send_request(lcdnw_pkg::KIND_INIT,     2'd3, 6'd63, 8'hFF, 16'hFFFF, 3'd7, 0);

    // Random: mostly legal cursor positions and digit counts
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) r_kind = lcdnw_pkg::KIND_INIT;
      else if (pick < 3) r_kind = lcdnw_pkg::KIND_CHAR;
      else if (pick < 7) r_kind = lcdnw_pkg::KIND_UNSIGNED;
      else r_kind = lcdnw_pkg::KIND_SIGNED;

      if ($urandom_range(0, 9) < 8) r_line = 2'($urandom_range(1, 2));
      else r_line = $urandom_range(0, 1) ? 2'd0 : 2'd3;

      if ($urandom_range(0, 9) < 8) r_col = 6'($urandom_range(1, 40));
      else r_col = 6'($urandom_range(0, 63));

      case ($urandom_range(0, 3))
        0: r_val = 16'($urandom_range(0, 65535));
        1: r_val = 16'($urandom_range(0, 999));
        2: begin
          case ($urandom_range(0, 4))
            0: r_val = 16'h0000;
            1: r_val = 16'h0001;
            2: r_val = 16'h7FFF;
            3: r_val = 16'h8000;
            default: r_val = 16'hFFFF - 16'($urandom_range(0, 9));
          endcase
        end
        default: r_val = 16'd0 - 16'($urandom_range(0, 999));
      endcase

      if ($urandom_range(0, 9) < 8) r_cnt = 3'($urandom_range(1, 5));
      else r_cnt = 3'($urandom_range(0, 7));

      // alternate bursts with no idling and random gaps
      if ((i / 32) % 3 == 1) gap = 0;
      else gap = $urandom_range(0, 9);

      // hold off once until every expected write has arrived
      if (i == RANDOM_REQUESTS / 2) begin
        start <= 1'b0;
        while (writes_sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        gap = 0;
      end

      send_request(r_kind, r_line, r_col, 8'($urandom_range(0, 255)), r_val, r_cnt, gap);
    end

    // Drain outstanding writes, then watch for strays
    start <= 1'b0;
    while (writes_sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (writes_sb.pending() != 0)
      writes_sb.report($sformatf("%0d expected writes never arrived", writes_sb.pending()));

    if (writes_sb.errors == 0) begin
      $display("char_lcd_number_writer_unit: match");
    end else begin
      $display("char_lcd_number_writer_unit: mismatch");
    end
    $finish;
  end

endmodule
